FILE: rtl/bhpe_pkg.sv
`timescale 1ns / 1ps

package bhpe_pkg;

  localparam int MAX_CELLS_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SLOTS         = 12;
  localparam int STEP_W        = 4;

  localparam int IN_W   = 144;
  localparam int OUT_W  = 96;
  localparam int KIND_W = 2;
  localparam int CELL_W = 8;
  localparam int SLOT_W = 4;
  localparam int COMP_W = 32;
  localparam int PAR_W  = 17;
  // {cell, side, slot} address, wide enough for 256 cells
  localparam int LA_W   = 13;

  // input word field offsets
  localparam int CELL_LO = 0;
  localparam int SIDE_LO = 8;
  localparam int SLOT_LO = 9;
  localparam int X_LO    = 13;
  localparam int Y_LO    = 45;
  localparam int Z_LO    = 77;
  localparam int U_LO    = 109;
  localparam int V_LO    = 126;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DERIV = 2'd2;

  typedef struct packed {
    logic              capture;
    logic              mem_we;
    logic              sq;
    logic              cube;
    logic              basis;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              rnd;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic zero;
    logic out_free;
  } sts_t;

  // patch vectors in accumulation order; twist terms are skipped
  function automatic logic [SLOT_W-1:0] step_slot(input logic [STEP_W-1:0] k);
    logic [SLOT_W-1:0] s;
    case (k)
      4'd0:    s = 4'd0;
      4'd1:    s = 4'd1;
      4'd2:    s = 4'd8;
      4'd3:    s = 4'd9;
      4'd4:    s = 4'd3;
      4'd5:    s = 4'd2;
      4'd6:    s = 4'd11;
      4'd7:    s = 4'd10;
      4'd8:    s = 4'd4;
      4'd9:    s = 4'd5;
      4'd10:   s = 4'd7;
      4'd11:   s = 4'd6;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] step_urole(input logic [STEP_W-1:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
      4'd4, 4'd5, 4'd6, 4'd7: r = 2'd1;
      4'd8, 4'd9:             r = 2'd2;
      default:                r = 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] step_vrole(input logic [STEP_W-1:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd4, 4'd8, 4'd10: r = 2'd0;
      4'd1, 4'd5, 4'd9, 4'd11: r = 2'd1;
      4'd2, 4'd6:              r = 2'd2;
      default:                 r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/bhpe_ctrl.sv
`timescale 1ns / 1ps

module bhpe_ctrl import bhpe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  sts_t              sts,
  output cmd_t              cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SQ    = 8'b0000_0010,
    S_CUBE  = 8'b0000_0100,
    S_BASIS = 8'b0000_1000,
    S_RUN   = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_RND   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    cmd.step   = step;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_LOAD: cmd.mem_we = 1'b1;
            KIND_VALUE, KIND_DERIV: begin
              cmd.capture = 1'b1;
              state_next  = S_SQ;
            end
            default: ;
          endcase
        end
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        state_next = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube   = 1'b1;
        state_next = S_BASIS;
      end
      S_BASIS: begin
        cmd.basis  = 1'b1;
        step_next  = '0;
        state_next = sts.zero ? S_DONE : S_RUN;
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (step == STEP_W'(SLOTS - 1)) begin
          state_next = S_DRAIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

FILE: rtl/bhpe_dp.sv
`timescale 1ns / 1ps

module bhpe_dp import bhpe_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  in_data,
  input  logic [KIND_W-1:0] in_kind,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data,
  output logic             out_sat
);

  localparam int DEPTH = MAX_CELLS * 2 * SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = FRAC_BITS + 1;
  localparam int BW    = FRAC_BITS + 4;
  localparam int PW    = 2 * BW;
  localparam int MW    = BW + COMP_W;
  localparam int ACW   = MW + 4;
  localparam int CW    = ((PAR_W > TW) ? PAR_W : TW) + 1;

  typedef logic signed [BW-1:0] basis_t [4];

  // input fields
  logic [CELL_W-1:0] cell_in;
  logic              side_in;
  logic [SLOT_W-1:0] slot_in;
  logic [PAR_W-1:0]  u_in, v_in;
  logic [CW-1:0]     one_c, u_c, v_c;

  assign cell_in = in_data[CELL_LO +: CELL_W];
  assign side_in = in_data[SIDE_LO];
  assign slot_in = in_data[SLOT_LO +: SLOT_W];
  assign u_in    = in_data[U_LO +: PAR_W];
  assign v_in    = in_data[V_LO +: PAR_W];
  assign one_c   = CW'(1) << FRAC_BITS;
  assign u_c     = (CW'(u_in) > one_c) ? one_c : CW'(u_in);
  assign v_c     = (CW'(v_in) > one_c) ? one_c : CW'(v_in);

  logic cell_ok;
  assign cell_ok = (int'(cell_in) < MAX_CELLS);

  // evaluation context
  logic            deriv, zero;
  logic [LA_W-1:0] base;
  logic [TW-1:0]   tu, tv, u2, v2, u3, v3;
  logic signed [BW-1:0] bu [4];
  logic signed [BW-1:0] bv [4];

  logic [2*TW-1:0] half_t, usq, vsq, ucb, vcb;
  assign half_t = (2*TW)'(1) << (FRAC_BITS - 1);
  assign usq = (2*TW)'(tu) * (2*TW)'(tu) + half_t;
  assign vsq = (2*TW)'(tv) * (2*TW)'(tv) + half_t;
  assign ucb = (2*TW)'(u2) * (2*TW)'(tu) + half_t;
  assign vcb = (2*TW)'(v2) * (2*TW)'(tv) + half_t;

  function automatic basis_t make_basis(input logic [TW-1:0] t1, input logic [TW-1:0] t2,
                                        input logic [TW-1:0] t3, input logic d);
    logic signed [BW-1:0] a1, a2, a3, one;
    basis_t b;
    a1  = $signed(BW'(t1));
    a2  = $signed(BW'(t2));
    a3  = $signed(BW'(t3));
    one = $signed(BW'(1) << FRAC_BITS);
    if (d) begin
      b[0] = BW'(6 * a2 - 6 * a1);
      b[1] = BW'(6 * a1 - 6 * a2);
      b[2] = BW'(3 * a2 - 4 * a1 + one);
      b[3] = BW'(3 * a2 - 2 * a1);
    end else begin
      b[0] = BW'(2 * a3 - 3 * a2 + one);
      b[1] = BW'(3 * a2 - 2 * a3);
      b[2] = BW'(a3 - 2 * a2 + a1);
      b[3] = BW'(a3 - a2);
    end
    return b;
  endfunction

  basis_t bu_n, bv_n;
  assign bu_n = make_basis(tu, u2, u3, deriv);
  assign bv_n = make_basis(tv, v2, v3, 1'b0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      deriv <= (in_kind == KIND_DERIV);
      zero  <= !cell_ok;
      base  <= LA_W'({cell_in, side_in}) * LA_W'(SLOTS);
      tu    <= TW'(u_c);
      tv    <= TW'(v_c);
    end
    if (cmd.sq) begin
      u2 <= TW'(usq >> FRAC_BITS);
      v2 <= TW'(vsq >> FRAC_BITS);
    end
    if (cmd.cube) begin
      u3 <= TW'(ucb >> FRAC_BITS);
      v3 <= TW'(vcb >> FRAC_BITS);
    end
    if (cmd.basis) begin
      for (int i = 0; i < 4; i++) begin
        bu[i] <= bu_n[i];
        bv[i] <= bv_n[i];
      end
    end
  end

  // patch memory, one x/y/z word per entry
  logic [OUT_W-1:0] mem [DEPTH];
  logic [OUT_W-1:0] mem_q;
  logic [LA_W-1:0]  waddr, raddr;
  logic [AW-1:0]    addr;
  logic             wr;

  assign wr    = cmd.mem_we && cell_ok && (slot_in < SLOT_W'(SLOTS));
  assign waddr = LA_W'({cell_in, side_in}) * LA_W'(SLOTS) + LA_W'(slot_in);
  assign raddr = base + LA_W'(step_slot(cmd.step));
  assign addr  = cmd.mem_we ? AW'(waddr) : AW'(raddr);

  always_ff @(posedge clk) begin
    if (wr) mem[addr] <= in_data[X_LO +: OUT_W];
    mem_q <= mem[addr];
  end

  // weight, product, accumulate pipeline
  logic v1, v2p, v3p;
  logic signed [PW-1:0]  p_reg, p_rnd;
  logic signed [BW-1:0]  w_reg;
  logic [OUT_W-1:0]      h_reg;
  logic signed [MW-1:0]  prod [3];
  logic signed [ACW-1:0] acc [3];
  logic signed [ACW-1:0] rres [3];
  logic signed [ACW-1:0] half_a;

  assign p_rnd  = p_reg + $signed(PW'(1) << (FRAC_BITS - 1));
  assign half_a = $signed(ACW'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2p <= 1'b0;
      v3p <= 1'b0;
    end else begin
      v1  <= cmd.issue;
      v2p <= v1;
      v3p <= v2p;
    end
  end

  always_ff @(posedge clk) begin
    p_reg <= PW'(bu[step_urole(cmd.step)]) * PW'(bv[step_vrole(cmd.step)]);
    w_reg <= BW'(p_rnd >>> FRAC_BITS);
    h_reg <= mem_q;
    for (int c = 0; c < 3; c++) begin
      prod[c] <= MW'(w_reg) * MW'($signed(h_reg[c*COMP_W +: COMP_W]));
      if (cmd.capture) begin
        acc[c] <= '0;
      end else if (v3p) begin
        acc[c] <= acc[c] + ACW'(prod[c]);
      end
      if (cmd.rnd) rres[c] <= (acc[c] + half_a) >>> FRAC_BITS;
    end
  end

  // saturation and output word
  logic signed [ACW-1:0] lim_hi, lim_lo;
  logic [OUT_W-1:0]      sat_data;
  logic [2:0]            sat_hit;

  assign lim_hi = $signed(ACW'(32'h7fff_ffff));
  assign lim_lo = -lim_hi - 1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat_hit[c] = 1'b0;
      if (rres[c] > lim_hi) begin
        sat_data[c*COMP_W +: COMP_W] = 32'h7fff_ffff;
        sat_hit[c] = 1'b1;
      end else if (rres[c] < lim_lo) begin
        sat_data[c*COMP_W +: COMP_W] = 32'h8000_0000;
        sat_hit[c] = 1'b1;
      end else begin
        sat_data[c*COMP_W +: COMP_W] = rres[c][COMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= zero ? '0 : sat_data;
      out_sat  <= zero ? 1'b0 : (|sat_hit);
    end
  end

  assign sts.busy     = v1 | v2p | v3p;
  assign sts.zero     = zero;
  assign sts.out_free = !out_valid || out_ready;

endmodule

FILE: rtl/bicubic_hermite_patch_eval_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Word                                  Side info
// s_*      in   cell,side,slot,load x/y/z,u,v         tuser: kind
// m_*      out  out x/y/z                             tuser: saturated
//
// A load writes the patch memory. An evaluate forms the squares, cubes and
// basis weights, makes twelve patch-memory reads on its single port, drains the
// weight/multiply/accumulate pipe, then rounds and outputs (zero if cell invalid).
// Reset clears control only; the patch memory is undefined until written.
// The next word is taken while a result waits in the output register.

module bicubic_hermite_patch_eval_unit import bhpe_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // cell[7:0] side[8] slot[12:9] load_x[44:13] load_y[76:45] load_z[108:77]
  // param_u[125:109] param_v[142:126] pad[143]
  input  logic [IN_W-1:0]   s_tdata,
  input  logic [KIND_W-1:0] s_tuser,   // kind
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // out_x[31:0] out_y[63:32] out_z[95:64]
  output logic [0:0]        m_tuser    // saturated
);

  cmd_t cmd;
  sts_t sts;

  bhpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bhpe_dp #(
    .MAX_CELLS (MAX_CELLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .in_kind   (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_sat   (m_tuser[0])
  );

endmodule
